// ----- sv/rbes_pkg.sv -----
// Shared types, constants and helper functions for the rigid body Euler step block.
package rbes_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int REG_W         = 31;
    localparam int CFG_IDX_W     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BODY_MASS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_FORCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE     = 3'd5;

    localparam logic [REG_W-1:0] BODY_MASS_RST     = 31'd65536;
    localparam logic [REG_W-1:0] TIME_STEP_RST     = 31'd1092;
    localparam logic [REG_W-1:0] GRAVITY_FORCE_RST = 31'd642253;
    localparam logic [REG_W-1:0] FRICTION_RST      = 31'd0;
    localparam logic [REG_W-1:0] DEAD_ZONE_RST     = 31'd6554;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic PASS_VEL = 1'b0;
    localparam logic PASS_POS = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FORCE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL,
        ST_SCALE,
        ST_ACC,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sh0000_0000_7FFF_FFFF;
        min_v = -64'sh0000_0000_8000_0000;
        if (v > max_v) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < min_v) begin
            sat32 = -32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [31:0] snap(input logic signed [31:0] v,
                                                input logic [REG_W-1:0] dz);
        snap = (mag32(v) < {1'b0, dz}) ? 32'sd0 : v;
    endfunction

endpackage

// ----- sv/rbes_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle, unsigned operands.
module rbes_div #(
    parameter int FRAC_BITS = rbes_pkg::FRAC_BITS_DEF,
    parameter int DW        = 32 + FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DW-1:0]            dividend,
    input  logic [rbes_pkg::REG_W-1:0] divisor,
    output logic                     done,
    output logic [DW-1:0]            quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [31:0]      rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [31:0]      trial;
    logic             q_bit;

    always_comb begin
        trial = {rem_reg[30:0], quo_reg[DW-1]};
        q_bit = (trial >= {1'b0, divisor});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = 32'd0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = q_bit ? (trial - {1'b0, divisor}) : trial;
            quo_next = {quo_reg[DW-2:0], q_bit};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/rbes_mul.sv -----
// Shared signed by unsigned multiplier with a registered product.
module rbes_mul (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [31:0]         a,
    input  logic [rbes_pkg::REG_W-1:0] b,
    output logic signed [63:0]         product
);

    logic signed [31:0] b_s;
    logic signed [63:0] prod_reg;

    assign b_s = $signed({1'b0, b});

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b_s;
        end
    end

    assign product = prod_reg;

endmodule

// ----- sv/rigid_body_euler_step.sv -----
// Top level of the rigid body Euler step: registers, sequencer and datapath.
//
// Each request on the s_ channel is one simulation tick: the summed force and
// an environment flag. The block answers with one result on the m_ channel:
// the new position, new velocity and a status bit. The user must write the
// configuration registers through cfg_wr_en / cfg_index / cfg_wr_data only
// while idle; the block itself does not enforce it. One request is in flight
// at a time; s_ready is high only when idle. The result is computed by three
// passes of the one-bit-per-cycle divider (one per axis) and six multiply,
// scale and accumulate passes through the shared multiplier.
// A tick with zero mass or dt is answered the cycle after acceptance with
// status set and the state left as it was.
// The result stays on the m_ ports with m_valid high until m_ready; no new
// request is taken before then.
// Reset clears position and velocity to zero and loads the register defaults.
module rigid_body_euler_step #(
    parameter int FRAC_BITS = rbes_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rbes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbes_pkg::REG_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [31:0]             s_force_x,
    input  logic signed [31:0]             s_force_y,
    input  logic signed [31:0]             s_force_z,
    input  logic                           s_apply_environment,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [31:0]             m_pos_x,
    output logic signed [31:0]             m_pos_y,
    output logic [30:0]                    m_pos_z,
    output logic signed [31:0]             m_vel_x,
    output logic signed [31:0]             m_vel_y,
    output logic signed [31:0]             m_vel_z,
    output logic                           m_status
);

    localparam int DW = 32 + FRAC_BITS;
    localparam logic signed [63:0] ROUND_BIAS = 64'((64'd1 << FRAC_BITS) - 64'd1);

    rbes_pkg::state_t state_reg, state_next;

    logic [rbes_pkg::REG_W-1:0] mass_reg, dt_reg, grav_reg, fric_x_reg, fric_y_reg, dz_reg;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] acc_reg [3];
    logic signed [31:0] frc_reg [3];

    logic signed [31:0] in_fx_reg, in_fy_reg, in_fz_reg;
    logic               in_env_reg;
    logic               status_reg;
    logic [1:0]         axis_reg;
    logic               pass_reg;
    logic signed [63:0] scaled_reg;

    logic               div_start;
    logic               div_done;
    logic [DW-1:0]      div_dividend;
    logic [DW-1:0]      div_quotient;
    logic               mul_en;
    logic signed [31:0] mul_a;
    logic signed [63:0] mul_product;

    logic               accept;
    logic               cfg_bad;
    logic               last_axis;

    logic signed [33:0] fx_sum, fy_sum, fz_sum;
    logic signed [31:0] f_cur;
    logic [63:0]        q_ext;
    logic signed [63:0] q_signed;
    logic signed [31:0] a_new;
    logic signed [31:0] acc_base;
    logic signed [63:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic signed [31:0] acc_result;

    assign accept    = s_valid && s_ready;
    assign cfg_bad   = (mass_reg == '0) || (dt_reg == '0);
    assign last_axis = (axis_reg == rbes_pkg::AXIS_Z);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rbes_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = cfg_bad ? rbes_pkg::ST_OUT : rbes_pkg::ST_FORCE;
                end
            end
            rbes_pkg::ST_FORCE:     state_next = rbes_pkg::ST_DIV_START;
            rbes_pkg::ST_DIV_START: state_next = rbes_pkg::ST_DIV_WAIT;
            rbes_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = last_axis ? rbes_pkg::ST_MUL : rbes_pkg::ST_DIV_START;
                end
            end
            rbes_pkg::ST_MUL:   state_next = rbes_pkg::ST_SCALE;
            rbes_pkg::ST_SCALE: state_next = rbes_pkg::ST_ACC;
            rbes_pkg::ST_ACC: begin
                if (last_axis && (pass_reg == rbes_pkg::PASS_POS)) begin
                    state_next = rbes_pkg::ST_OUT;
                end else begin
                    state_next = rbes_pkg::ST_MUL;
                end
            end
            rbes_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = rbes_pkg::ST_IDLE;
                end
            end
            default: state_next = rbes_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        div_start = 1'b0;
        mul_en    = 1'b0;
        case (state_reg)
            rbes_pkg::ST_IDLE:      s_ready   = 1'b1;
            rbes_pkg::ST_DIV_START: div_start = 1'b1;
            rbes_pkg::ST_MUL:       mul_en    = 1'b1;
            rbes_pkg::ST_OUT:       m_valid   = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        // environment forces use the velocity from before this tick
        fx_sum = 34'(in_fx_reg);
        fy_sum = 34'(in_fy_reg);
        fz_sum = 34'(in_fz_reg);
        if (in_env_reg) begin
            fz_sum = fz_sum - $signed({3'b0, grav_reg});
            if (vel_reg[0] > 32'sd0) begin
                fx_sum = fx_sum - $signed({3'b0, fric_x_reg});
            end else if (vel_reg[0] < 32'sd0) begin
                fx_sum = fx_sum + $signed({3'b0, fric_x_reg});
            end
            if (vel_reg[1] > 32'sd0) begin
                fy_sum = fy_sum - $signed({3'b0, fric_y_reg});
            end else if (vel_reg[1] < 32'sd0) begin
                fy_sum = fy_sum + $signed({3'b0, fric_y_reg});
            end
        end

        f_cur        = frc_reg[axis_reg];
        div_dividend = {rbes_pkg::mag32(f_cur), {FRAC_BITS{1'b0}}};

        q_ext    = 64'(div_quotient);
        q_signed = f_cur[31] ? -$signed(q_ext) : $signed(q_ext);
        a_new    = rbes_pkg::sat32(q_signed);
        if (!last_axis) begin
            a_new = rbes_pkg::snap(a_new, dz_reg);
        end

        mul_a    = (pass_reg == rbes_pkg::PASS_POS) ? vel_reg[axis_reg] : acc_reg[axis_reg];
        acc_base = (pass_reg == rbes_pkg::PASS_POS) ? pos_reg[axis_reg] : vel_reg[axis_reg];
        acc_sum  = 64'(acc_base) + scaled_reg;
        acc_sat  = rbes_pkg::sat32(acc_sum);
        acc_result = acc_sat;
        if (pass_reg == rbes_pkg::PASS_VEL) begin
            if (!last_axis) begin
                acc_result = rbes_pkg::snap(acc_sat, dz_reg);
            end
        end else if (last_axis && acc_sat[31]) begin
            acc_result = 32'sd0;  // ground floor
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg   <= rbes_pkg::BODY_MASS_RST;
            dt_reg     <= rbes_pkg::TIME_STEP_RST;
            grav_reg   <= rbes_pkg::GRAVITY_FORCE_RST;
            fric_x_reg <= rbes_pkg::FRICTION_RST;
            fric_y_reg <= rbes_pkg::FRICTION_RST;
            dz_reg     <= rbes_pkg::DEAD_ZONE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rbes_pkg::REG_BODY_MASS:     mass_reg   <= cfg_wr_data;
                rbes_pkg::REG_TIME_STEP:     dt_reg     <= cfg_wr_data;
                rbes_pkg::REG_GRAVITY_FORCE: grav_reg   <= cfg_wr_data;
                rbes_pkg::REG_FRICTION_X:    fric_x_reg <= cfg_wr_data;
                rbes_pkg::REG_FRICTION_Y:    fric_y_reg <= cfg_wr_data;
                rbes_pkg::REG_DEAD_ZONE:     dz_reg     <= cfg_wr_data;
                default: begin
                    mass_reg <= mass_reg;
                end
            endcase
        end
    end

    // sequencer and body state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rbes_pkg::ST_IDLE;
            axis_reg   <= rbes_pkg::AXIS_X;
            pass_reg   <= rbes_pkg::PASS_VEL;
            status_reg <= rbes_pkg::STATUS_OK;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= 32'sd0;
                vel_reg[i] <= 32'sd0;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                rbes_pkg::ST_IDLE: begin
                    if (accept) begin
                        status_reg <= cfg_bad ? rbes_pkg::STATUS_ERR : rbes_pkg::STATUS_OK;
                    end
                    axis_reg <= rbes_pkg::AXIS_X;
                    pass_reg <= rbes_pkg::PASS_VEL;
                end
                rbes_pkg::ST_DIV_WAIT: begin
                    if (div_done) begin
                        axis_reg <= last_axis ? rbes_pkg::AXIS_X : axis_reg + 2'd1;
                    end
                end
                rbes_pkg::ST_ACC: begin
                    if (pass_reg == rbes_pkg::PASS_POS) begin
                        pos_reg[axis_reg] <= acc_result;
                    end else begin
                        vel_reg[axis_reg] <= acc_result;
                    end
                    if (last_axis) begin
                        axis_reg <= rbes_pkg::AXIS_X;
                        pass_reg <= rbes_pkg::PASS_POS;
                    end else begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                default: begin
                    axis_reg <= axis_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_fx_reg  <= s_force_x;
            in_fy_reg  <= s_force_y;
            in_fz_reg  <= s_force_z;
            in_env_reg <= s_apply_environment;
        end
        if (state_reg == rbes_pkg::ST_FORCE) begin
            frc_reg[0] <= rbes_pkg::sat32(64'(fx_sum));
            frc_reg[1] <= rbes_pkg::sat32(64'(fy_sum));
            frc_reg[2] <= rbes_pkg::sat32(64'(fz_sum));
        end
        if ((state_reg == rbes_pkg::ST_DIV_WAIT) && div_done) begin
            acc_reg[axis_reg] <= a_new;
        end
        if (state_reg == rbes_pkg::ST_SCALE) begin
            // divide by 2^FRAC_BITS truncating toward zero
            scaled_reg <= (mul_product + (mul_product[63] ? ROUND_BIAS : 64'sd0))
                          >>> FRAC_BITS;
        end
    end

    rbes_div #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (mass_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    rbes_mul u_mul (
        .aclk    (aclk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (dt_reg),
        .product (mul_product)
    );

    assign m_pos_x  = pos_reg[0];
    assign m_pos_y  = pos_reg[1];
    assign m_pos_z  = pos_reg[2][30:0];
    assign m_vel_x  = vel_reg[0];
    assign m_vel_y  = vel_reg[1];
    assign m_vel_z  = vel_reg[2];
    assign m_status = status_reg;

endmodule

// ----- bench/rigid_body_euler_step_tb.sv -----
// Self-checking bench for the rigid body Euler step: directed and random force ticks.
`timescale 1ns / 100ps

module rigid_body_euler_step_tb;

    localparam int FRAC            = rbes_pkg::FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int TAIL_CYCLES     = 200;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int RANDOM_PHASES   = 6;
    localparam int MAX_PRINTED     = 100;

    typedef logic [rbes_pkg::REG_W-1:0]     reg_val_t;
    typedef logic [rbes_pkg::CFG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_SPARE_6 = 3'd6;
    localparam reg_idx_t REG_SPARE_7 = 3'd7;

    localparam logic [31:0] F_MAX   = 32'h7fff_ffff;
    localparam logic [31:0] F_MIN   = 32'h8000_0000;
    localparam reg_val_t    REG_MAX = 31'h7fff_ffff;
    localparam longint      S32_MAX = 64'sd2147483647;
    localparam longint      S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        env;
    } force_tick_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [30:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic        status;
    } motion_t;

    logic                   aclk                = 1'b0;
    logic                   aresetn             = 1'b0;
    logic                   cfg_wr_en           = 1'b0;
    reg_idx_t               cfg_index           = '0;
    reg_val_t               cfg_wr_data         = '0;
    logic                   s_valid             = 1'b0;
    logic                   s_ready;
    logic signed [31:0]     s_force_x           = '0;
    logic signed [31:0]     s_force_y           = '0;
    logic signed [31:0]     s_force_z           = '0;
    logic                   s_apply_environment = 1'b0;
    logic                   m_valid;
    logic                   m_ready             = 1'b0;
    logic signed [31:0]     m_pos_x;
    logic signed [31:0]     m_pos_y;
    logic [30:0]            m_pos_z;
    logic signed [31:0]     m_vel_x;
    logic signed [31:0]     m_vel_y;
    logic signed [31:0]     m_vel_z;
    logic                   m_status;

    // body state and register copies kept by the predictor
    logic signed [31:0] body_pos_x, body_pos_y, body_pos_z;
    logic signed [31:0] body_vel_x, body_vel_y, body_vel_z;
    reg_val_t           mass_q, dt_q, gravity_q, fric_x_q, fric_y_q, zone_q;

    force_tick_t pending_ticks[$];
    motion_t     expected_motion[$];

    int idle_pct       = 9;
    int ticks_queued   = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int err_results    = 0;
    int settings_used  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    rigid_body_euler_step dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_force_x           (s_force_x),
        .s_force_y           (s_force_y),
        .s_force_z           (s_force_z),
        .s_apply_environment (s_apply_environment),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pos_x             (m_pos_x),
        .m_pos_y             (m_pos_y),
        .m_pos_z             (m_pos_z),
        .m_vel_x             (m_vel_x),
        .m_vel_y             (m_vel_y),
        .m_vel_z             (m_vel_z),
        .m_status            (m_status)
    );

    always #2 aclk = ~aclk;

    function automatic logic signed [31:0] clamp_s32(input longint v);
        if (v > S32_MAX) return F_MAX;
        if (v < S32_MIN) return F_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] deadband(input logic signed [31:0] v);
        longint mag;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        return (mag < longint'(zone_q)) ? 32'sd0 : v;
    endfunction

    // product with dt, rescaled and truncated toward zero
    function automatic longint dt_scale(input logic signed [31:0] v);
        return (longint'(v) * longint'(dt_q)) / (longint'(1) << FRAC);
    endfunction

    function automatic logic signed [31:0] force_to_accel(input logic signed [31:0] f);
        return clamp_s32((longint'(f) * (longint'(1) << FRAC)) / longint'(mass_q));
    endfunction

    function automatic motion_t advance_body(input logic signed [31:0] fx_in,
                                             input logic signed [31:0] fy_in,
                                             input logic signed [31:0] fz_in,
                                             input logic               env);
        motion_t            r;
        longint             fx, fy, fz;
        logic signed [31:0] ax, ay, az;
        r.status = rbes_pkg::STATUS_OK;
        if (mass_q == '0 || dt_q == '0) begin
            r.status = rbes_pkg::STATUS_ERR;
        end else begin
            fx = fx_in;
            fy = fy_in;
            fz = fz_in;
            if (env) begin
                fz -= longint'(gravity_q);
                // friction opposes the velocity held before this tick
                if (body_vel_x > 0) fx -= longint'(fric_x_q);
                else if (body_vel_x < 0) fx += longint'(fric_x_q);
                if (body_vel_y > 0) fy -= longint'(fric_y_q);
                else if (body_vel_y < 0) fy += longint'(fric_y_q);
            end
            ax = deadband(force_to_accel(clamp_s32(fx)));
            ay = deadband(force_to_accel(clamp_s32(fy)));
            az = force_to_accel(clamp_s32(fz));
            body_vel_x = deadband(clamp_s32(longint'(body_vel_x) + dt_scale(ax)));
            body_vel_y = deadband(clamp_s32(longint'(body_vel_y) + dt_scale(ay)));
            body_vel_z = clamp_s32(longint'(body_vel_z) + dt_scale(az));
            body_pos_x = clamp_s32(longint'(body_pos_x) + dt_scale(body_vel_x));
            body_pos_y = clamp_s32(longint'(body_pos_y) + dt_scale(body_vel_y));
            body_pos_z = clamp_s32(longint'(body_pos_z) + dt_scale(body_vel_z));
            if (body_pos_z < 0) body_pos_z = 32'sd0;
        end
        r.pos_x = body_pos_x;
        r.pos_y = body_pos_y;
        r.pos_z = body_pos_z[30:0];
        r.vel_x = body_vel_x;
        r.vel_y = body_vel_y;
        r.vel_z = body_vel_z;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH result %0d %s: got %h expected %h",
                     results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic set_register(input reg_idx_t idx, input reg_val_t val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            rbes_pkg::REG_BODY_MASS:     mass_q    = val;
            rbes_pkg::REG_TIME_STEP:     dt_q      = val;
            rbes_pkg::REG_GRAVITY_FORCE: gravity_q = val;
            rbes_pkg::REG_FRICTION_X:    fric_x_q  = val;
            rbes_pkg::REG_FRICTION_Y:    fric_y_q  = val;
            rbes_pkg::REG_DEAD_ZONE:     zone_q    = val;
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic apply_setting(input reg_val_t mass, input reg_val_t dt,
                                 input reg_val_t grav, input reg_val_t fx,
                                 input reg_val_t fy, input reg_val_t zone);
        set_register(rbes_pkg::REG_BODY_MASS, mass);
        set_register(rbes_pkg::REG_TIME_STEP, dt);
        set_register(rbes_pkg::REG_GRAVITY_FORCE, grav);
        set_register(rbes_pkg::REG_FRICTION_X, fx);
        set_register(rbes_pkg::REG_FRICTION_Y, fy);
        set_register(rbes_pkg::REG_DEAD_ZONE, zone);
        close_writes();
    endtask

    task automatic queue_tick(input logic [31:0] fx, input logic [31:0] fy,
                              input logic [31:0] fz, input logic env);
        force_tick_t t;
        t.fx  = fx;
        t.fy  = fy;
        t.fz  = fz;
        t.env = env;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // every tick answers once, so idle means all queued ticks have answered
    task automatic wait_drained();
        while (results_seen < ticks_queued) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_force();
        case ($urandom_range(9))
            0, 1:          return $urandom();
            2, 3, 4, 5, 6: return $urandom_range(32'h0080_0000) - 32'h0040_0000;
            7, 8:          return $urandom_range(32'h0000_8000) - 32'h0000_4000;
            default: begin
                case ($urandom_range(3))
                    0:       return F_MAX;
                    1:       return F_MIN;
                    2:       return 32'h0;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    // a request that was accepted leaves a predicted result behind
    always @(posedge aclk) begin : tick_driver
        force_tick_t nxt;
        logic        holding;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            holding = s_valid;
            if (s_valid && s_ready) begin
                expected_motion.push_back(advance_body(s_force_x, s_force_y, s_force_z,
                                                       s_apply_environment));
                ticks_sent++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = pending_ticks.pop_front();
                    s_valid             <= 1'b1;
                    s_force_x           <= nxt.fx;
                    s_force_y           <= nxt.fy;
                    s_force_z           <= nxt.fz;
                    s_apply_environment <= nxt.env;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        motion_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_motion.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'h0, 32'h0);
                end else begin
                    want = expected_motion.pop_front();
                    if (want.status == rbes_pkg::STATUS_ERR) err_results++;
                    check_field("pos_x", m_pos_x, want.pos_x);
                    check_field("pos_y", m_pos_y, want.pos_y);
                    check_field("pos_z", {1'b0, m_pos_z}, {1'b0, want.pos_z});
                    check_field("vel_x", m_vel_x, want.vel_x);
                    check_field("vel_y", m_vel_y, want.vel_y);
                    check_field("vel_z", m_vel_z, want.vel_z);
                    check_field("status", {31'd0, m_status}, {31'd0, want.status});
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d of %0d results seen", results_seen, ticks_queued);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        body_pos_x = '0;
        body_pos_y = '0;
        body_pos_z = '0;
        body_vel_x = '0;
        body_vel_y = '0;
        body_vel_z = '0;
        mass_q     = rbes_pkg::BODY_MASS_RST;
        dt_q       = rbes_pkg::TIME_STEP_RST;
        gravity_q  = rbes_pkg::GRAVITY_FORCE_RST;
        fric_x_q   = rbes_pkg::FRICTION_RST;
        fric_y_q   = rbes_pkg::FRICTION_RST;
        zone_q     = rbes_pkg::DEAD_ZONE_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: rest, free fall onto the floor, extremes, dead zone edges
        queue_tick(32'h0, 32'h0, 32'h0, 1'b0);
        queue_tick(32'h0, 32'h0, 32'h0, 1'b1);
        queue_tick(32'h0, 32'h0, F_MAX, 1'b0);
        queue_tick(F_MAX, F_MIN, F_MAX, 1'b0);
        queue_tick(F_MIN, F_MAX, F_MIN, 1'b1);
        queue_tick(-32'sd6000, 32'sd6000, 32'h0, 1'b0);
        queue_tick(32'sd6554, -32'sd6554, 32'h0, 1'b0);
        queue_tick(32'hffff_ffff, 32'h1, 32'h0, 1'b1);
        wait_drained();

        // friction against both signs of velocity; spare indexes must be ignored
        set_register(rbes_pkg::REG_FRICTION_X, 31'h0010_0000);
        set_register(rbes_pkg::REG_FRICTION_Y, 31'h0008_0000);
        set_register(REG_SPARE_6, REG_MAX);
        set_register(REG_SPARE_7, REG_MAX);
        close_writes();
        queue_tick(32'h0040_0000, -32'sh0040_0000, 32'h0, 1'b1);
        queue_tick(32'h0, 32'h0, 32'h0, 1'b1);
        queue_tick(-32'sh0100_0000, 32'h0100_0000, 32'h0020_0000, 1'b1);
        queue_tick(32'h0, 32'h0, 32'h0, 1'b1);
        wait_drained();

        // zero mass, then zero dt: error status, state held
        set_register(rbes_pkg::REG_BODY_MASS, 31'd0);
        close_writes();
        queue_tick(F_MAX, 32'h0, 32'h0, 1'b1);
        queue_tick(32'h0, 32'h0, 32'h0, 1'b0);
        wait_drained();
        set_register(rbes_pkg::REG_BODY_MASS, rbes_pkg::BODY_MASS_RST);
        set_register(rbes_pkg::REG_TIME_STEP, 31'd0);
        close_writes();
        queue_tick(F_MIN, F_MAX, 32'h1, 1'b1);
        wait_drained();

        // register extremes: first into saturation, then a huge mass and dead zone
        apply_setting(31'd1, REG_MAX, REG_MAX, REG_MAX, REG_MAX, 31'd0);
        queue_tick(F_MAX, F_MIN, 32'h0, 1'b1);
        queue_tick(32'h0, 32'h0, 32'h0, 1'b1);
        queue_tick(F_MIN, F_MAX, F_MAX, 1'b0);
        queue_tick(32'h1, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        wait_drained();
        apply_setting(REG_MAX, 31'd1, 31'd0, 31'd0, 31'd0, REG_MAX);
        queue_tick(F_MAX, F_MIN, F_MAX, 1'b0);
        queue_tick(F_MIN, F_MAX, F_MIN, 1'b1);
        queue_tick(32'h0, 32'h0, 32'h0, 1'b0);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_setting(rbes_pkg::BODY_MASS_RST, rbes_pkg::TIME_STEP_RST,
                                 rbes_pkg::GRAVITY_FORCE_RST, rbes_pkg::FRICTION_RST,
                                 rbes_pkg::FRICTION_RST, rbes_pkg::DEAD_ZONE_RST);
                3: apply_setting(reg_val_t'($urandom()), reg_val_t'($urandom()),
                                 reg_val_t'($urandom()), reg_val_t'($urandom()),
                                 reg_val_t'($urandom()), reg_val_t'($urandom()));
                4: apply_setting(reg_val_t'($urandom_range(32'h0010_0000, 32'h0000_1000)),
                                 reg_val_t'($urandom_range(32'h0000_4000, 32'h1)),
                                 reg_val_t'($urandom_range(32'h0040_0000)),
                                 reg_val_t'($urandom_range(32'h0100_0000)),
                                 reg_val_t'($urandom_range(32'h0100_0000)), 31'd0);
                default: apply_setting(
                             reg_val_t'($urandom_range(32'h0010_0000, 32'h0000_1000)),
                             reg_val_t'($urandom_range(32'h0000_4000, 32'h1)),
                             reg_val_t'($urandom_range(32'h0040_0000)),
                             reg_val_t'($urandom_range(32'h0040_0000)),
                             reg_val_t'($urandom_range(32'h0040_0000)),
                             reg_val_t'($urandom_range(32'h0001_0000)));
            endcase
            // one phase runs with both sides always ready
            idle_pct = (phase == 2) ? 0 : 9;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_tick(rand_force(), rand_force(), rand_force(), 1'($urandom_range(1)));
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_motion.size() != 0)
            report_mismatch("results never delivered", expected_motion.size(), 32'h0);

        $display("Sent %0d force ticks under %0d register settings", ticks_sent, settings_used);
        $display("%0d answered with error status, %0d mismatches", err_results, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
